/* design/brim_pkg.sv */
// Shared types, constants and microcode table for the breath rate / I:E ratio meter.
// Used by brim_seq, the top level and the testbench; depends on nothing.
package brim_pkg;

    localparam int TIME_BITS_DEF = 16;

    // 60000 ms per minute, times ten for tenths of a breath
    localparam int RATE_NUM   = 600000;
    localparam int RATE_NUM_W = 20;

    localparam logic [7:0]  TICK_RESET = 8'd10;
    localparam logic [7:0]  RATIO_UNIT = 8'd10;
    localparam logic [7:0]  RATIO_SAT  = 8'hFF;
    localparam logic [15:0] OUT16_SAT  = 16'hFFFF;

    // breath stage codes
    localparam logic [2:0] STG_NONE      = 3'd0;
    localparam logic [2:0] STG_INS_START = 3'd1;
    localparam logic [2:0] STG_INS_END   = 3'd2;
    localparam logic [2:0] STG_EX_START  = 3'd3;
    localparam logic [2:0] STG_EX_END    = 3'd4;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TAKE,
        OP_DIV_RATE,
        OP_SET_RATE,
        OP_DIV_RATIO,
        OP_SET_RATIO,
        OP_UPDATE
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_ITEM,
        C_PLAIN,
        C_DIV_BUSY,
        C_OUT_BLOCKED
    } cond_t;

    // jump to target when cond holds, else fall through (or back to start if last)
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  last;
    } ucode_t;

    typedef struct packed {
        logic no_item;
        logic plain;
        logic div_busy;
        logic out_blocked;
    } status_t;

    localparam step_t ST_TAKE       = 4'd0;
    localparam step_t ST_CHECK      = 4'd1;
    localparam step_t ST_RATE_GO    = 4'd2;
    localparam step_t ST_RATE_WAIT  = 4'd3;
    localparam step_t ST_RATE_SET   = 4'd4;
    localparam step_t ST_RATIO_GO   = 4'd5;
    localparam step_t ST_RATIO_WAIT = 4'd6;
    localparam step_t ST_RATIO_SET  = 4'd7;
    localparam step_t ST_UPDATE     = 4'd8;

    function automatic ucode_t ucode_rom(input step_t step);
        ucode_t w;
        case (step)
            ST_TAKE:       w = '{OP_TAKE,      C_NO_ITEM,     ST_TAKE,       1'b0};
            ST_CHECK:      w = '{OP_NONE,      C_PLAIN,       ST_UPDATE,     1'b0};
            ST_RATE_GO:    w = '{OP_DIV_RATE,  C_NEVER,       ST_TAKE,       1'b0};
            ST_RATE_WAIT:  w = '{OP_NONE,      C_DIV_BUSY,    ST_RATE_WAIT,  1'b0};
            ST_RATE_SET:   w = '{OP_SET_RATE,  C_NEVER,       ST_TAKE,       1'b0};
            ST_RATIO_GO:   w = '{OP_DIV_RATIO, C_NEVER,       ST_TAKE,       1'b0};
            ST_RATIO_WAIT: w = '{OP_NONE,      C_DIV_BUSY,    ST_RATIO_WAIT, 1'b0};
            ST_RATIO_SET:  w = '{OP_SET_RATIO, C_NEVER,       ST_TAKE,       1'b0};
            ST_UPDATE:     w = '{OP_UPDATE,    C_OUT_BLOCKED, ST_UPDATE,     1'b1};
            default:       w = '{OP_NONE,      C_NEVER,       ST_TAKE,       1'b1};
        endcase
        return w;
    endfunction

endpackage

/* design/brim_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; used by the meter top level for both rate and ratio.
module brim_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 17
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvs_reg, dvs_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W+1:0]  trial;
    logic                  fits;

    // zero divisor: every trial fits, quotient comes out all ones
    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial   = {1'b0, shifted} - {2'b00, dvs_reg};
        fits    = ~trial[DIVISOR_W+1];

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DIVIDEND_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? trial[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next  = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* design/brim_seq.sv */
// Microcode sequencer: step counter, control word fetch and conditional jumps.
// Depends on brim_pkg for the control word layout and program table.
module brim_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  brim_pkg::status_t status,
    output brim_pkg::op_t     op
);

    brim_pkg::step_t  step_reg, step_next;
    brim_pkg::ucode_t word;
    logic             jump;

    always_comb begin
        word = brim_pkg::ucode_rom(step_reg);
        case (word.cond)
            brim_pkg::C_NEVER:       jump = 1'b0;
            brim_pkg::C_NO_ITEM:     jump = status.no_item;
            brim_pkg::C_PLAIN:       jump = status.plain;
            brim_pkg::C_DIV_BUSY:    jump = status.div_busy;
            brim_pkg::C_OUT_BLOCKED: jump = status.out_blocked;
            default:                 jump = 1'b0;
        endcase
        if (jump) begin
            step_next = word.target;
        end else if (word.last) begin
            step_next = brim_pkg::ST_TAKE;
        end else begin
            step_next = step_reg + brim_pkg::step_t'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= brim_pkg::ST_TAKE;
        end else begin
            step_reg <= step_next;
        end
    end

    assign op = word.op;

endmodule

/* design/breath_rate_and_ie_ratio_meter.sv */
// Breath rate and I:E ratio meter: top level with datapath, sequencer and divider.
// Depends on brim_pkg, brim_seq, brim_div.
// Plain tick: after accept, CHECK, then UPDATE loads the result register; the next item
//   is taken once UPDATE is done. Breath end: rate, then ratio, by two serial divisions
//   on one shared divider of DIV_W = max(20, TIME_BITS+4) bits, ahead of the next item.
// Reset (synchronous, aresetn low): times, held rate/ratio and previous stage cleared,
//   tick length back to 10 ms, output register empty.
module breath_rate_and_ie_ratio_meter #(
    parameter int TIME_BITS = brim_pkg::TIME_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // tick items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_stage,
    // results
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_rate_x10,
    output logic [7:0]  m_ins_ratio_x10,
    output logic [7:0]  m_ex_ratio_x10,
    output logic [15:0] m_ins_elapsed_ms,
    output logic [15:0] m_ex_elapsed_ms,
    output logic        m_breath_done
);

    // divider sizing: quotient must hold 600000 and 10*longest phase time
    localparam int DIV_W = (TIME_BITS + 4 > brim_pkg::RATE_NUM_W) ?
                           TIME_BITS + 4 : brim_pkg::RATE_NUM_W;
    localparam int DVS_W = TIME_BITS + 1;
    // width used to saturate times down to the 16-bit outputs
    localparam int EXT_W = (TIME_BITS > 16) ? TIME_BITS : 16;

    // ---------------- state ----------------
    logic [7:0]           tick_reg;
    logic [2:0]           stage_reg;
    logic [2:0]           prev_reg;
    logic [TIME_BITS-1:0] ins_reg, ins_next;
    logic [TIME_BITS-1:0] ex_reg,  ex_next;
    logic [15:0]          hrate_reg;
    logic [7:0]           hins_reg;
    logic [7:0]           hex_reg;

    // output register; the sequencer can take the next item while it waits
    logic                 mv_reg;
    logic [15:0]          o_rate_reg, o_ins_t_reg, o_ex_t_reg;
    logic [7:0]           o_ins_r_reg, o_ex_r_reg;
    logic                 o_done_reg;

    // ---------------- control ----------------
    brim_pkg::op_t     op;
    brim_pkg::status_t status;
    logic              breath;
    logic              accept;
    logic              div_start;
    logic              div_busy;
    logic [DIV_W-1:0]  quotient;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;

    // ratio operands
    logic                 ins_short;
    logic [TIME_BITS-1:0] longer, shorter;
    logic [DIV_W-1:0]     longer_x10;
    logic [DVS_W-1:0]     total;

    logic [EXT_W-1:0]     ins_ext, ex_ext;
    logic [TIME_BITS-1:0] ins_base, ex_base;
    logic                 out_blocked;
    logic                 out_load;

    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                     input logic [7:0] d);
        logic [TIME_BITS:0] s;
        s = {1'b0, t} + (TIME_BITS+1)'(d);
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

    assign s_ready = (op == brim_pkg::OP_TAKE);
    assign accept  = s_valid & s_ready;

    // breath completes when inspiration starts right after expiration end
    assign breath = (stage_reg == brim_pkg::STG_INS_START) &&
                    (prev_reg == brim_pkg::STG_EX_END);

    assign out_blocked = mv_reg & ~m_ready;
    // result register takes the finished item
    assign out_load    = (op == brim_pkg::OP_UPDATE) && !out_blocked;

    always_comb begin
        status             = '0;
        status.no_item     = ~s_valid;
        status.plain       = ~breath;
        status.div_busy    = div_busy;
        status.out_blocked = out_blocked;
    end

    brim_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .op      (op)
    );

    // ---------------- divider operands ----------------
    // ties go to inspiration as the shorter phase
    assign ins_short  = (ins_reg <= ex_reg);
    assign longer     = ins_short ? ex_reg : ins_reg;
    assign shorter    = ins_short ? ins_reg : ex_reg;
    // 10*x as 8x + 2x
    assign longer_x10 = (DIV_W'(longer) << 3) + (DIV_W'(longer) << 1);
    assign total      = {1'b0, ins_reg} + {1'b0, ex_reg};

    assign div_start = (op == brim_pkg::OP_DIV_RATE) || (op == brim_pkg::OP_DIV_RATIO);
    assign dividend  = (op == brim_pkg::OP_DIV_RATE) ? DIV_W'(brim_pkg::RATE_NUM)
                                                     : longer_x10;
    // a zero divisor yields an all-ones quotient, which saturates below
    assign divisor   = (op == brim_pkg::OP_DIV_RATE) ? total : DVS_W'(shorter);

    brim_div #(
        .DIVIDEND_W (DIV_W),
        .DIVISOR_W  (DVS_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // ---------------- phase time update ----------------
    always_comb begin
        ins_base = breath ? '0 : ins_reg;
        ex_base  = breath ? '0 : ex_reg;
        ins_next = ins_reg;
        ex_next  = ex_reg;
        case (stage_reg)
            brim_pkg::STG_NONE: begin
                ins_next = '0;
                ex_next  = '0;
            end
            brim_pkg::STG_INS_START: begin
                ins_next = sat_add(ins_base, tick_reg);
                ex_next  = ex_base;
            end
            brim_pkg::STG_INS_END: begin
                ins_next = sat_add(ins_reg, tick_reg);
            end
            brim_pkg::STG_EX_START, brim_pkg::STG_EX_END: begin
                ex_next = sat_add(ex_reg, tick_reg);
            end
            default: begin
                // error and unused codes leave the times alone
            end
        endcase
        ins_ext = EXT_W'(ins_next);
        ex_ext  = EXT_W'(ex_next);
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= brim_pkg::TICK_RESET;
            prev_reg  <= brim_pkg::STG_NONE;
            ins_reg   <= '0;
            ex_reg    <= '0;
            hrate_reg <= '0;
            hins_reg  <= '0;
            hex_reg   <= '0;
            mv_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                tick_reg <= cfg_wr_data;
            end
            // a new result may replace the one leaving in the same cycle
            if (out_load) begin
                mv_reg <= 1'b1;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
            case (op)
                brim_pkg::OP_SET_RATE: begin
                    hrate_reg <= (quotient > DIV_W'(brim_pkg::OUT16_SAT)) ?
                                 brim_pkg::OUT16_SAT : quotient[15:0];
                end
                brim_pkg::OP_SET_RATIO: begin
                    if (ins_short) begin
                        hins_reg <= brim_pkg::RATIO_UNIT;
                        hex_reg  <= (quotient > DIV_W'(brim_pkg::RATIO_SAT)) ?
                                    brim_pkg::RATIO_SAT : quotient[7:0];
                    end else begin
                        hins_reg <= (quotient > DIV_W'(brim_pkg::RATIO_SAT)) ?
                                    brim_pkg::RATIO_SAT : quotient[7:0];
                        hex_reg  <= brim_pkg::RATIO_UNIT;
                    end
                end
                brim_pkg::OP_UPDATE: begin
                    if (!out_blocked) begin
                        ins_reg  <= ins_next;
                        ex_reg   <= ex_next;
                        prev_reg <= stage_reg;
                    end
                end
                default: begin
                end
            endcase
        end

        // payload
        if (accept) begin
            stage_reg <= s_stage;
        end
        if (out_load) begin
            o_rate_reg  <= hrate_reg;
            o_ins_r_reg <= hins_reg;
            o_ex_r_reg  <= hex_reg;
            o_ins_t_reg <= (ins_ext > EXT_W'(brim_pkg::OUT16_SAT)) ?
                           brim_pkg::OUT16_SAT : ins_ext[15:0];
            o_ex_t_reg  <= (ex_ext > EXT_W'(brim_pkg::OUT16_SAT)) ?
                           brim_pkg::OUT16_SAT : ex_ext[15:0];
            o_done_reg  <= breath;
        end
    end

    assign m_valid          = mv_reg;
    assign m_rate_x10       = o_rate_reg;
    assign m_ins_ratio_x10  = o_ins_r_reg;
    assign m_ex_ratio_x10   = o_ex_r_reg;
    assign m_ins_elapsed_ms = o_ins_t_reg;
    assign m_ex_elapsed_ms  = o_ex_t_reg;
    assign m_breath_done    = o_done_reg;

endmodule

/* design/brim_checker.sv */
// Port-level checks for the breath meter, bound to the top level.
// Depends only on the top level's port list.
module brim_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [15:0] m_rate_x10,
    input logic [7:0]  m_ins_ratio_x10,
    input logic [7:0]  m_ex_ratio_x10,
    input logic        m_breath_done
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rate_x10) && $stable(m_breath_done))
        else $error("result changed while stalled");

    // a finished breath always shows the shorter phase as 10
    a_ratio_unit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_breath_done |-> (m_ins_ratio_x10 == 8'd10 || m_ex_ratio_x10 == 8'd10))
        else $error("breath result without unit ratio");

    // one item in flight: ready drops right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while busy");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind breath_rate_and_ie_ratio_meter brim_checker u_brim_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_rate_x10      (m_rate_x10),
    .m_ins_ratio_x10 (m_ins_ratio_x10),
    .m_ex_ratio_x10  (m_ex_ratio_x10),
    .m_breath_done   (m_breath_done)
);

/* test/tb.sv */
// Self-checking testbench for breath_rate_and_ie_ratio_meter: per-tick rate and I:E ratio results.
// Needs brim_pkg for the stage codes and the default time width; reads no files.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // stage codes the package does not name
    localparam logic [2:0] STAGE_ERROR  = 3'd5;
    localparam logic [2:0] STAGE_SPARE6 = 3'd6;
    localparam logic [2:0] STAGE_SPARE7 = 3'd7;

    localparam longint TIME_CAP      = (64'd1 << brim_pkg::TIME_BITS_DEF) - 1;
    localparam longint TENTHS_PER_MS = 600000;   // 60000 ms/min, times ten
    localparam longint RATE_CAP      = 65535;
    localparam logic [7:0] RATIO_ONE = 8'd10;
    localparam logic [7:0] RATIO_CAP = 8'hFF;
    localparam logic [7:0] TICK_AT_RESET = 8'd10;

    localparam int LONG_HOLD   = 120;   // receiver hold-off, long enough to back up the input
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [15:0] rate;
        logic [7:0]  ins_ratio;
        logic [7:0]  ex_ratio;
        logic [15:0] ins_ms;
        logic [15:0] ex_ms;
        logic        done;
    } meter_out_t;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_valid     = 1'b0;
    logic [2:0]  s_stage     = 3'd0;
    logic        m_ready     = 1'b0;
    logic        s_ready;
    logic        m_valid;
    logic [15:0] m_rate_x10;
    logic [7:0]  m_ins_ratio_x10;
    logic [7:0]  m_ex_ratio_x10;
    logic [15:0] m_ins_elapsed_ms;
    logic [15:0] m_ex_elapsed_ms;
    logic        m_breath_done;

    // ticks waiting to be driven, and results owed by the block (oldest first)
    logic [2:0]  stage_pending[$];
    meter_out_t  meter_expect[$];

    // predictor copy of the meter state
    logic [7:0]  tick_ms;
    logic [2:0]  prev_stage;
    longint      ins_ms;
    longint      ex_ms;
    logic [15:0] held_rate;
    logic [7:0]  held_ins_ratio;
    logic [7:0]  held_ex_ratio;

    int  fault_count    = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  s_fire         = 1'b0;
    bit  quiet_tail     = 1'b0;   // no idling on either side once set
    bit  long_hold_req  = 1'b0;
    bit  long_hold_done = 1'b0;
    bit  long_hold_on   = 1'b0;

    always #5 aclk = ~aclk;

    breath_rate_and_ie_ratio_meter uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_stage          (s_stage),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rate_x10       (m_rate_x10),
        .m_ins_ratio_x10  (m_ins_ratio_x10),
        .m_ex_ratio_x10   (m_ex_ratio_x10),
        .m_ins_elapsed_ms (m_ins_elapsed_ms),
        .m_ex_elapsed_ms  (m_ex_elapsed_ms),
        .m_breath_done    (m_breath_done)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint sat_time(longint t, logic [7:0] d);
        longint s;
        s = t + d;
        return (s > TIME_CAP) ? TIME_CAP : s;
    endfunction

    function automatic logic [15:0] clip16(longint v);
        return (v > RATE_CAP) ? 16'hFFFF : v[15:0];
    endfunction

    // longer phase over shorter phase, times ten; zero divisor pins at the cap
    function automatic logic [7:0] ratio_x10(longint longer, longint shorter);
        longint q;
        if (shorter == 0)
            return RATIO_CAP;
        q = (longer * 10) / shorter;
        return (q > 255) ? RATIO_CAP : q[7:0];
    endfunction

    // One tick through the meter: updates the predictor state, returns the result item.
    function automatic meter_out_t advance_meter(logic [2:0] stage);
        meter_out_t o;
        longint total;
        longint q;
        o.done = 1'b0;
        case (stage)
            brim_pkg::STG_NONE: begin
                ins_ms = 0;
                ex_ms  = 0;
            end
            brim_pkg::STG_INS_START: begin
                // breath closes only when inspiration follows expiration end directly
                if (prev_stage == brim_pkg::STG_EX_END) begin
                    total = ins_ms + ex_ms;
                    if (total == 0)
                        q = RATE_CAP;
                    else
                        q = TENTHS_PER_MS / total;
                    held_rate = clip16(q);
                    if (ins_ms <= ex_ms) begin
                        held_ins_ratio = RATIO_ONE;
                        held_ex_ratio  = ratio_x10(ex_ms, ins_ms);
                    end else begin
                        held_ins_ratio = ratio_x10(ins_ms, ex_ms);
                        held_ex_ratio  = RATIO_ONE;
                    end
                    ins_ms = 0;
                    ex_ms  = 0;
                    o.done = 1'b1;
                end
                ins_ms = sat_time(ins_ms, tick_ms);
            end
            brim_pkg::STG_INS_END: ins_ms = sat_time(ins_ms, tick_ms);
            brim_pkg::STG_EX_START, brim_pkg::STG_EX_END: ex_ms = sat_time(ex_ms, tick_ms);
            default: ;   // error and spare codes leave the times alone
        endcase
        prev_stage  = stage;
        o.rate      = held_rate;
        o.ins_ratio = held_ins_ratio;
        o.ex_ratio  = held_ex_ratio;
        o.ins_ms    = clip16(ins_ms);
        o.ex_ms     = clip16(ex_ms);
        return o;
    endfunction

    function automatic void note_fault(string msg);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("tb: mismatch at %0t: %s", $time, msg);
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
            note_fault($sformatf("%s expected %0d, got %0d", name, want, got));
    endfunction

    // ------------------------------------------------------------------
    // Driver: acceptance seen at the rising edge, next item put up at the falling edge
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready)
            meter_expect.push_back(advance_meter(s_stage));
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_fire)) begin
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (stage_pending.size() != 0) begin
                s_stage <= stage_pending.pop_front();
                s_valid <= 1'b1;
                // keep offering items while the receiver is held off
                if (!quiet_tail && !long_hold_on && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 9);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready bursts plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req && !long_hold_done) begin
                stall_left     = LONG_HOLD - 1;
                long_hold_done = 1'b1;
                long_hold_on   = 1'b1;
                m_ready <= 1'b0;
            end else begin
                long_hold_on = 1'b0;
                if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(0, 8);   // start a stall burst of random length
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: each accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        meter_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (meter_expect.size() == 0) begin
                note_fault("result item with nothing expected");
            end else begin
                want = meter_expect.pop_front();
                check_field("rate_x10", want.rate, m_rate_x10);
                check_field("ins_ratio_x10", 16'(want.ins_ratio), 16'(m_ins_ratio_x10));
                check_field("ex_ratio_x10", 16'(want.ex_ratio), 16'(m_ex_ratio_x10));
                check_field("ins_elapsed_ms", want.ins_ms, m_ins_elapsed_ms);
                check_field("ex_elapsed_ms", want.ex_ms, m_ex_elapsed_ms);
                check_field("breath_done", 16'(want.done), 16'(m_breath_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // well-formed breath: ins start, ins end ticks, ex start, ex end ticks
    task automatic push_breath(int n_ins, int n_ex);
        stage_pending.push_back(brim_pkg::STG_INS_START);
        repeat (n_ins) stage_pending.push_back(brim_pkg::STG_INS_END);
        stage_pending.push_back(brim_pkg::STG_EX_START);
        repeat (n_ex) stage_pending.push_back(brim_pkg::STG_EX_END);
    endtask

    // mostly breaths with random phase lengths, some lopsided ones, some junk runs
    task automatic queue_random(int n);
        int made;
        int kind;
        int a;
        int b;
        made = 0;
        while (made < n) begin
            kind = $urandom_range(0, 9);
            a = $urandom_range(0, 6);
            b = $urandom_range(1, 6);
            if (kind == 6) begin
                a = $urandom_range(0, 1);     // short ins: ex ratio near or past the cap
                b = $urandom_range(20, 40);
            end else if (kind == 7) begin
                a = $urandom_range(20, 40);   // short ex
                b = $urandom_range(1, 2);
            end
            if (kind < 8) begin
                push_breath(a, b);
                made += a + b + 2;
            end else begin
                a = $urandom_range(1, 4);
                repeat (a) stage_pending.push_back(3'($urandom_range(0, 7)));
                made += a;
            end
        end
    endtask

    // block idle: nothing queued, nothing on the wire, nothing owed
    task automatic drain();
        while (stage_pending.size() != 0 || s_valid || meter_expect.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tick_length(logic [7:0] v);
        drain();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        tick_ms     = v;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
    endtask

    initial begin
        logic [2:0] opening[$];

        tick_ms        = TICK_AT_RESET;
        prev_stage     = brim_pkg::STG_NONE;
        ins_ms         = 0;
        ex_ms          = 0;
        held_rate      = '0;
        held_ins_ratio = '0;
        held_ex_ratio  = '0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed, reset tick length of 10 ms
        opening = {STAGE_SPARE7, STAGE_SPARE6, STAGE_ERROR, brim_pkg::STG_NONE,
                   brim_pkg::STG_INS_START, brim_pkg::STG_EX_END,
                   brim_pkg::STG_INS_START,                               // minimal breath
                   brim_pkg::STG_INS_END, brim_pkg::STG_INS_END,
                   brim_pkg::STG_EX_START, brim_pkg::STG_EX_END,
                   brim_pkg::STG_INS_START,                               // ins longer
                   STAGE_ERROR, brim_pkg::STG_NONE, brim_pkg::STG_EX_END,
                   brim_pkg::STG_INS_START,                               // no ins: ratio cap
                   brim_pkg::STG_EX_END, brim_pkg::STG_EX_END,
                   brim_pkg::STG_INS_START};                              // ex longer
        foreach (opening[i]) stage_pending.push_back(opening[i]);
        queue_random(40);

        // 1 ms tick: total of one ms pushes the rate past 16 bits
        write_tick_length(8'd1);
        stage_pending.push_back(brim_pkg::STG_NONE);
        stage_pending.push_back(brim_pkg::STG_EX_END);
        stage_pending.push_back(brim_pkg::STG_INS_START);
        queue_random(30);

        // zero tick: breath with no time at all
        write_tick_length(8'd0);
        stage_pending.push_back(brim_pkg::STG_NONE);
        stage_pending.push_back(brim_pkg::STG_EX_END);
        stage_pending.push_back(brim_pkg::STG_INS_START);
        queue_random(20);

        // largest tick: inspiration time runs into saturation
        write_tick_length(8'd255);
        push_breath(258, 1);
        stage_pending.push_back(brim_pkg::STG_INS_START);

        // mid-range tick with the receiver backing up the block
        write_tick_length(8'($urandom_range(2, 254)));
        queue_random(20);
        long_hold_req = 1'b1;

        // closing stretch at full rate on both sides
        write_tick_length(8'($urandom_range(2, 254)));
        quiet_tail = 1'b1;
        queue_random(20);

        drain();
        repeat (20) @(posedge aclk);
        if (fault_count == 0 && meter_expect.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin
        #10_000_000;
        $display("tb: done, errors");
        $finish;
    end

endmodule

/* sim.f */
design/brim_pkg.sv
design/brim_div.sv
design/brim_seq.sv
design/breath_rate_and_ie_ratio_meter.sv
design/brim_checker.sv
test/tb.sv
